// ===== rtl/w36alu_pkg.sv =====
package w36alu_pkg;

    localparam int unsigned WordW    = 36;
    localparam int unsigned OpW      = 9;
    localparam int unsigned DivSteps = WordW;
    localparam int unsigned NumStages = DivSteps + 1;

    localparam logic [OpW-1:0] GRP_MASK = 9'o774;
    localparam logic [OpW-1:0] OP_MOVN  = 9'o210;
    localparam logic [OpW-1:0] OP_MOVM  = 9'o214;
    localparam logic [OpW-1:0] OP_IMUL  = 9'o220;
    localparam logic [OpW-1:0] OP_MUL   = 9'o224;
    localparam logic [OpW-1:0] OP_IDIV  = 9'o230;
    localparam logic [OpW-1:0] OP_ADD   = 9'o270;
    localparam logic [OpW-1:0] OP_SUB   = 9'o274;

    localparam logic [WordW-1:0] SIGN_BIT = {1'b1, {(WordW-1){1'b0}}};

    typedef enum logic [1:0] {
        K_PASS = 2'd0,
        K_MUL  = 2'd1,
        K_IMUL = 2'd2,
        K_IDIV = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t            kind;
        logic [WordW-1:0] rh;
        logic [WordW-1:0] rl;
        logic [WordW-1:0] dv;
        logic [WordW-1:0] ex;
        logic             neg;
        logic             an;
        logic             cr0;
        logic             cr1;
        logic             ov;
        logic             tr1;
        logic             nd;
        logic             si;
    } stage_t;

    function automatic logic [WordW-1:0] neg36(input logic [WordW-1:0] v);
        return ~v + WordW'(1);
    endfunction

endpackage

// ===== rtl/w36alu_if.sv =====
interface w36alu_req_if;
    logic                           valid;
    logic                           ready;
    logic [w36alu_pkg::OpW-1:0]     opcode;
    logic [w36alu_pkg::WordW-1:0]   operand_a;
    logic [w36alu_pkg::WordW-1:0]   operand_b;

    modport source (output valid, opcode, operand_a, operand_b, input ready);
    modport sink   (input valid, opcode, operand_a, operand_b, output ready);
endinterface

interface w36alu_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [w36alu_pkg::WordW-1:0]   result_high;
    logic [w36alu_pkg::WordW-1:0]   result_low;
    logic                           carry_zero;
    logic                           carry_one;
    logic                           overflow;
    logic                           trap_one;
    logic                           no_divide;
    logic                           store_inhibit;

    modport source (output valid, result_high, result_low, carry_zero, carry_one, overflow,
                    trap_one, no_divide, store_inhibit, input ready);
    modport sink   (input valid, result_high, result_low, carry_zero, carry_one, overflow,
                    trap_one, no_divide, store_inhibit, output ready);
endinterface

// ===== rtl/word36_integer_alu.sv =====
// 36-bit fixed-point arithmetic unit: negate, magnitude, add, subtract, single and
// double-word multiply and integer divide. Fully pipelined: one instruction can be
// accepted every cycle while the output is not stalled, and its result is presented
// after 38 register stages (one decode stage, 36 one-bit divide stages and one sign
// fix-up stage; multiply results ride in the same pipeline). The whole pipeline
// advances together, so it holds while the output transfer is stalled, and
// req.ready follows rsp.ready or an empty output.
module word36_integer_alu (
    input logic          clk,
    input logic          rst_n,
    w36alu_req_if.sink   req,
    w36alu_rsp_if.source rsp
);

    localparam int unsigned N = w36alu_pkg::NumStages;

    w36alu_pkg::stage_t dec_st;
    w36alu_pkg::stage_t st_pipe [0:N];
    logic [N:0]         vld_pipe;
    logic               en;

    assign en        = rsp.ready || !vld_pipe[N];
    assign req.ready = en;

    w36alu_decode u_decode (
        .opcode    (req.opcode),
        .operand_a (req.operand_a),
        .operand_b (req.operand_b),
        .st        (dec_st)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_pipe[0] <= 1'b0;
        end
        else if (en)
        begin
            vld_pipe[0] <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_pipe[0] <= dec_st;
        end
    end

    for (genvar k = 1; k <= N; k++)
    begin : g_stage
        w36alu_stage #(
            .STEP (k - 1)
        ) u_stage (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .vld_in  (vld_pipe[k-1]),
            .st_in   (st_pipe[k-1]),
            .vld_reg (vld_pipe[k]),
            .st_reg  (st_pipe[k])
        );
    end

    assign rsp.valid         = vld_pipe[N];
    assign rsp.result_high   = st_pipe[N].rh;
    assign rsp.result_low    = st_pipe[N].rl;
    assign rsp.carry_zero    = st_pipe[N].cr0;
    assign rsp.carry_one     = st_pipe[N].cr1;
    assign rsp.overflow      = st_pipe[N].ov;
    assign rsp.trap_one      = st_pipe[N].tr1;
    assign rsp.no_divide     = st_pipe[N].nd;
    assign rsp.store_inhibit = st_pipe[N].si;

    a_nd_flags: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.no_divide |-> rsp.store_inhibit && rsp.overflow && rsp.trap_one)
        else $error("no-divide without its companion flags");

    a_ov_trap: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.overflow |-> rsp.trap_one)
        else $error("overflow without trap request");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.result_high)
            && $stable(rsp.result_low))
        else $error("stalled result changed");

    a_out_kind: assert property (@(posedge clk) disable iff (!rst_n)
        vld_pipe[N] |-> st_pipe[N].kind == w36alu_pkg::K_PASS)
        else $error("unfinished item reached output");

endmodule

// ===== rtl/w36alu_decode.sv =====
module w36alu_decode (
    input  logic [w36alu_pkg::OpW-1:0]   opcode,
    input  logic [w36alu_pkg::WordW-1:0] operand_a,
    input  logic [w36alu_pkg::WordW-1:0] operand_b,
    output w36alu_pkg::stage_t           st
);

    localparam int unsigned W = w36alu_pkg::WordW;

    logic [w36alu_pkg::OpW-1:0] grp;
    logic [W-1:0]               ma;
    logic [W-1:0]               mb;
    logic [W-1:0]               bb;
    logic                       cin;
    logic [W:0]                 sum;
    logic [W-1:0]               sum_low;

    always_comb
    begin
        grp     = opcode & w36alu_pkg::GRP_MASK;
        ma      = operand_a[W-1] ? w36alu_pkg::neg36(operand_a) : operand_a;
        mb      = operand_b[W-1] ? w36alu_pkg::neg36(operand_b) : operand_b;
        cin     = (grp == w36alu_pkg::OP_SUB);
        bb      = cin ? ~operand_b : operand_b;
        sum     = {1'b0, operand_a} + {1'b0, bb} + {{W{1'b0}}, cin};
        sum_low = {1'b0, operand_a[W-2:0]} + {1'b0, bb[W-2:0]} + {{(W-1){1'b0}}, cin};

        st      = '0;
        st.kind = w36alu_pkg::K_PASS;
        st.rh   = operand_a;

        if (grp == w36alu_pkg::OP_MOVN || (grp == w36alu_pkg::OP_MOVM && operand_a[W-1]))
        begin
            st.cr1 = (operand_a[W-2:0] == '0);
            st.cr0 = (operand_a == '0);
            st.ov  = st.cr0 ^ st.cr1;
            st.tr1 = st.ov || (operand_a == w36alu_pkg::SIGN_BIT);
            st.rh  = w36alu_pkg::neg36(operand_a);
        end
        else if (grp == w36alu_pkg::OP_ADD || grp == w36alu_pkg::OP_SUB)
        begin
            st.cr1 = sum_low[W-1];
            st.cr0 = sum[W];
            st.ov  = st.cr0 ^ st.cr1;
            st.tr1 = st.ov;
            st.rh  = sum[W-1:0];
        end
        else if (grp == w36alu_pkg::OP_IMUL || grp == w36alu_pkg::OP_MUL)
        begin
            st.kind = (grp == w36alu_pkg::OP_MUL) ? w36alu_pkg::K_MUL : w36alu_pkg::K_IMUL;
            st.neg  = operand_a[W-1] ^ operand_b[W-1];
            st.rh   = ma;
            st.rl   = mb;
        end
        else if (grp == w36alu_pkg::OP_IDIV)
        begin
            if (mb == '0 || (operand_a == w36alu_pkg::SIGN_BIT && mb == W'(1)))
            begin
                st.nd = 1'b1;
                st.ov = 1'b1;
                st.tr1 = 1'b1;
                st.si = 1'b1;
            end
            else
            begin
                st.kind = w36alu_pkg::K_IDIV;
                st.an   = operand_a[W-1];
                st.neg  = operand_a[W-1] ^ operand_b[W-1];
                st.rh   = ma;
                st.dv   = mb;
            end
        end
    end

endmodule

// ===== rtl/w36alu_stage.sv =====
module w36alu_stage #(
    parameter int unsigned STEP = 0
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               vld_in,
    input  w36alu_pkg::stage_t st_in,
    output logic               vld_reg,
    output w36alu_pkg::stage_t st_reg
);

    localparam int unsigned W  = w36alu_pkg::WordW;
    localparam int unsigned HW = W / 2;

    w36alu_pkg::stage_t st_next;
    logic [W-1:0]       shifted;
    logic [W:0]         diff;
    logic [2*W-1:0]     prod;
    logic [W-1:0]       hi;
    logic [W-2:0]       lo;
    logic [W-2:0]       nlo;
    logic [W-1:0]       nl;
    logic [W-1:0]       hi_neg;

    always_comb
    begin
        st_next = st_in;
        shifted = {st_in.rl[W-2:0], st_in.rh[W-1]};
        diff    = {1'b0, shifted} - {1'b0, st_in.dv};
        prod    = ((2*W)'(st_in.ex) << W)
                + (((2*W)'(st_in.rl) + (2*W)'(st_in.dv)) << HW)
                + (2*W)'(st_in.rh);
        hi      = st_in.rh;
        lo      = st_in.rl[W-2:0];
        nlo     = ~lo + (W-1)'(1);
        nl      = {1'b0, ~lo} + W'(1);
        hi_neg  = ~hi + {{(W-1){1'b0}}, nl[W-1]};

        if (STEP < w36alu_pkg::DivSteps && st_in.kind == w36alu_pkg::K_IDIV)
        begin
            if (!diff[W])
            begin
                st_next.rl = diff[W-1:0];
                st_next.rh = {st_in.rh[W-2:0], 1'b1};
            end
            else
            begin
                st_next.rl = shifted;
                st_next.rh = {st_in.rh[W-2:0], 1'b0};
            end
        end

        if (STEP == w36alu_pkg::DivSteps && st_in.kind == w36alu_pkg::K_IDIV)
        begin
            st_next.kind = w36alu_pkg::K_PASS;
            st_next.rh   = st_in.neg ? w36alu_pkg::neg36(st_in.rh) : st_in.rh;
            st_next.rl   = st_in.an ? w36alu_pkg::neg36(st_in.rl) : st_in.rl;
        end

        if (st_in.kind == w36alu_pkg::K_MUL || st_in.kind == w36alu_pkg::K_IMUL)
        begin
            if (STEP == 0)
            begin
                // four 18x18 partial products
                st_next.rh = W'(st_in.rh[HW-1:0]) * W'(st_in.rl[HW-1:0]);
                st_next.rl = W'(st_in.rh[W-1:HW]) * W'(st_in.rl[HW-1:0]);
                st_next.dv = W'(st_in.rh[HW-1:0]) * W'(st_in.rl[W-1:HW]);
                st_next.ex = W'(st_in.rh[W-1:HW]) * W'(st_in.rl[W-1:HW]);
            end
            else if (STEP == 1)
            begin
                st_next.rh  = prod[2*W-2:W-1];
                st_next.rl  = {1'b0, prod[W-2:0]};
                st_next.neg = st_in.neg && (prod != '0);
            end
            else if (STEP == 2)
            begin
                st_next.kind = w36alu_pkg::K_PASS;
                if (st_in.kind == w36alu_pkg::K_IMUL)
                begin
                    if (st_in.neg)
                    begin
                        st_next.ov = (hi > W'(1)) || (hi == W'(1) && lo != '0);
                        st_next.rh = {1'b1, nlo};
                    end
                    else
                    begin
                        st_next.ov = (hi != '0);
                        st_next.rh = {1'b0, lo};
                    end
                    st_next.rl = st_next.rh;
                end
                else
                begin
                    st_next.ov = hi[W-1];
                    if (st_in.neg)
                    begin
                        st_next.rh = hi_neg;
                        st_next.rl = {hi_neg[W-1], nl[W-2:0]};
                    end
                    else
                    begin
                        st_next.rh = hi;
                        st_next.rl = {hi[W-1], lo};
                    end
                end
                st_next.tr1 = st_next.ov;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg <= st_next;
        end
    end

endmodule
